@@ hw/rtl/gpc_pkg.sv @@
// Shared types, constants and helper functions for the GPIO pin controller.
// Used by gpc_state_mem, gpc_exec and gpio_pin_controller; depends on nothing.
`default_nettype none

package gpc_pkg;

    localparam int NUM_PINS   = 106;
    localparam int PIN_W      = 7;
    localparam int PORT_COUNT = 8;

    localparam logic [PIN_W-1:0] PORT_SIZE [PORT_COUNT] = '{
        7'd22, 7'd0, 7'd17, 7'd18, 7'd16, 7'd7, 7'd14, 7'd12
    };

    localparam logic [2:0]       PORT_EMPTY      = 3'd1;
    localparam logic [PIN_W-1:0] PWM_PIN         = 7'd6;
    localparam logic [3:0]       PWM_MODE_CODE   = 4'd8;
    localparam logic [3:0]       MAX_PLAIN_MODE  = 4'd7;
    localparam logic [2:0]       PWM_STORED_MODE = 3'd3;
    localparam logic [2:0]       MODE_DISABLED   = 3'd7;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_PIN  = 2'd1;
    localparam logic [1:0] STATUS_BAD_MODE = 2'd2;

    typedef enum logic [2:0] {
        OP_SET_MODE = 3'd0,
        OP_GET_MODE = 3'd1,
        OP_SET_PULL = 3'd2,
        OP_GET_PULL = 3'd3,
        OP_WRITE    = 3'd4,
        OP_READ     = 3'd5,
        OP_TOGGLE   = 3'd6,
        OP_RELEASE  = 3'd7
    } opcode_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [PIN_W-1:0] pin;
        logic [3:0]       value;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] read_value;
        logic [2:0] port_index;
        logic [4:0] bit_offset;
    } out_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] port;
        logic [4:0] bit_off;
    } loc_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] pull_hw;
        logic       level;
        logic       saved_mode_valid;
        logic [2:0] saved_mode;
        logic       saved_pull_valid;
        logic [1:0] saved_pull;
    } pin_state_t;

    localparam pin_state_t PIN_STATE_RESET = '{
        mode:             MODE_DISABLED,
        pull_hw:          2'd0,
        level:            1'b0,
        saved_mode_valid: 1'b0,
        saved_mode:       3'd0,
        saved_pull_valid: 1'b0,
        saved_pull:       2'd0
    };

    typedef struct packed {
        logic             en;
        logic [PIN_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic             en;
        logic [PIN_W-1:0] addr;
        pin_state_t       data;
    } wr_req_t;

    // A nonzero pull code has both bits inverted in the hardware coding.
    function automatic logic [1:0] pull_swap(logic [1:0] code);
        return (code == 2'd0) ? 2'd0 : (code ^ 2'b11);
    endfunction

    // Splits a flat pin number into port and offset; ok is low beyond the last port.
    function automatic loc_t locate(logic [PIN_W-1:0] pin);
        loc_t             r;
        logic [PIN_W-1:0] base;
        logic             found;
        r     = '0;
        base  = '0;
        found = 1'b0;
        for (int k = 0; k < PORT_COUNT; k++) begin
            if (!found && (pin >= base) && (pin < base + PORT_SIZE[k])) begin
                found     = 1'b1;
                r.port    = 3'(k);
                r.bit_off = 5'(pin - base);
            end
            base = base + PORT_SIZE[k];
        end
        r.ok = found;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gpc_state_mem.sv @@
// Per-pin state memory with valid bits, registered read and write bypass.
// Depends on gpc_pkg.
`default_nettype none

module gpc_state_mem
    import gpc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire rd_req_t    rd_req,
    input  wire wr_req_t    wr_req,
    output pin_state_t      rd_data
);

    pin_state_t          state_mem_reg [NUM_PINS];
    logic [NUM_PINS-1:0] valid_reg;
    pin_state_t          rd_mem_reg;
    logic                rd_valid_reg;
    logic                byp_reg;
    pin_state_t          byp_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            state_mem_reg[wr_req.addr] <= wr_req.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_req.en) begin
            valid_reg[wr_req.addr] <= 1'b1;
        end
    end

    // A write to the address being read in the same cycle overtakes the stored entry.
    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_mem_reg   <= state_mem_reg[rd_req.addr];
            rd_valid_reg <= valid_reg[rd_req.addr];
            byp_reg      <= wr_req.en && (wr_req.addr == rd_req.addr);
            byp_data_reg <= wr_req.data;
        end
    end

    always_comb begin
        if (byp_reg) begin
            rd_data = byp_data_reg;
        end else if (rd_valid_reg) begin
            rd_data = rd_mem_reg;
        end else begin
            rd_data = PIN_STATE_RESET;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/gpc_exec.sv @@
// Operation unit: decodes one transaction against the pin's state and forms the result.
// Depends on gpc_pkg.
`default_nettype none

module gpc_exec
    import gpc_pkg::*;
(
    input  wire in_t        item,
    input  wire loc_t       loc,
    input  wire pin_state_t st,
    output out_t            res,
    output pin_state_t      st_next
);

    logic       mode_ok;
    logic [2:0] new_mode;

    always_comb begin
        res      = '0;
        st_next  = st;
        mode_ok  = 1'b0;
        new_mode = '0;
        if (!loc.ok) begin
            res.status = STATUS_BAD_PIN;
        end else begin
            res.port_index = loc.port;
            res.bit_offset = loc.bit_off;
            unique case (item.opcode)
                OP_SET_MODE: begin
                    if (item.value <= MAX_PLAIN_MODE) begin
                        mode_ok  = 1'b1;
                        new_mode = item.value[2:0];
                    end else if ((item.value == PWM_MODE_CODE) && (item.pin == PWM_PIN)) begin
                        mode_ok  = 1'b1;
                        new_mode = PWM_STORED_MODE;
                    end else begin
                        res.status = STATUS_BAD_MODE;
                    end
                    if (mode_ok) begin
                        if (!st.saved_mode_valid) begin
                            st_next.saved_mode       = st.mode;
                            st_next.saved_mode_valid = 1'b1;
                        end
                        st_next.mode = new_mode;
                    end
                end
                OP_GET_MODE: begin
                    res.read_value = st.mode;
                end
                OP_SET_PULL: begin
                    if (!st.saved_pull_valid) begin
                        st_next.saved_pull       = pull_swap(st.pull_hw);
                        st_next.saved_pull_valid = 1'b1;
                    end
                    st_next.pull_hw = pull_swap(item.value[1:0]);
                end
                OP_GET_PULL: begin
                    res.read_value = {1'b0, pull_swap(st.pull_hw)};
                end
                OP_WRITE: begin
                    st_next.level = (item.value != 4'd0);
                end
                OP_READ: begin
                    res.read_value = {2'b00, st.level};
                end
                OP_TOGGLE: begin
                    st_next.level = ~st.level;
                end
                OP_RELEASE: begin
                    if (st.saved_mode_valid) begin
                        st_next.mode             = st.saved_mode;
                        st_next.saved_mode_valid = 1'b0;
                    end
                    if (st.saved_pull_valid) begin
                        st_next.pull_hw          = pull_swap(st.saved_pull);
                        st_next.saved_pull_valid = 1'b0;
                    end
                end
                default: begin
                    res = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/gpio_pin_controller.sv @@
// Top level of the GPIO pin controller: input stage, state memory, operation unit, result register.
// Depends on gpc_pkg, gpc_state_mem and gpc_exec.
//
//   Channel   Direction  Payload  Handshake
//   s_        in         in_t     s_valid / s_ready
//   m_        out        out_t    m_valid / m_ready
//
// One transaction is accepted per cycle while s_ready is high; its result passes the registered read
// of the per-pin state memory and then the result register before it is presented on m_;
// the write-back of one transaction is bypassed to the next one.
// Reset is synchronous and clears the per-pin valid bits at once, so no clearing pass runs.
// A stalled result holds the middle stage, and input stalls only when both stages are full.
`default_nettype none

module gpio_pin_controller
    import gpc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic       s1_valid_reg;
    in_t        s1_item_reg;
    loc_t       s1_loc_reg;
    logic       m_valid_reg;
    out_t       m_data_reg;

    logic       s_accept;
    logic       advance;
    loc_t       loc_in;
    rd_req_t    rd_req;
    wr_req_t    wr_req;
    pin_state_t st_cur;
    pin_state_t st_next;
    out_t       res;

    assign loc_in   = locate(s_data.pin);
    assign advance  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign rd_req.en   = s_accept && loc_in.ok;
    assign rd_req.addr = s_data.pin;

    assign wr_req.en   = advance && s1_loc_reg.ok;
    assign wr_req.addr = s1_item_reg.pin;
    assign wr_req.data = st_next;

    gpc_state_mem u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_data (st_cur)
    );

    gpc_exec u_exec (
        .item    (s1_item_reg),
        .loc     (s1_loc_reg),
        .st      (st_cur),
        .res     (res),
        .st_next (st_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= s_data;
            s1_loc_reg  <= loc_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_valid_reg && !m_ready)
            |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("Middle stage lost its transaction during a result stall.");

    a_advance_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("An advancing transaction produced no result.");

    a_bad_pin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.status == STATUS_BAD_PIN))
            |-> ((m_data_reg.read_value == 3'd0) && (m_data_reg.port_index == 3'd0)
                 && (m_data_reg.bit_offset == 5'd0)))
        else $error("Invalid pin result carries nonzero fields.");

    a_no_empty_port: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.port_index != PORT_EMPTY))
        else $error("Result reports the empty port.");

    a_write_valid_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_req.en |-> (s1_loc_reg.ok && (s1_item_reg.pin < PIN_W'(NUM_PINS))))
        else $error("State write to a pin outside the memory.");

endmodule

`default_nettype wire
